// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/sprd_pkg.sv -----
// ---------------------------------------------------------------------------
// sprd_pkg
// codes and constants of the sync packet row deframer
// ---------------------------------------------------------------------------
package sprd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic [7:0] cfg_index_t;

  localparam kind_t KIND_SYNC    = 3'd0;
  localparam kind_t KIND_LENGTH  = 3'd1;
  localparam kind_t KIND_EXCODE  = 3'd2;
  localparam kind_t KIND_CODE    = 3'd3;
  localparam kind_t KIND_VLEN    = 3'd4;
  localparam kind_t KIND_VALUE   = 3'd5;
  localparam kind_t KIND_CHKSUM  = 3'd6;
  localparam kind_t KIND_RAW     = 3'd7;

  localparam status_t STATUS_NONE     = 3'd0;
  localparam status_t STATUS_OK       = 3'd1;
  localparam status_t STATUS_BAD_SUM  = 3'd2;
  localparam status_t STATUS_TOO_LONG = 3'd3;
  localparam status_t STATUS_RESERVED = 3'd4;
  localparam status_t STATUS_ZERO_LEN = 3'd5;
  localparam status_t STATUS_OVERRUN  = 3'd6;

  localparam cfg_index_t REG_MODE   = 8'd0;
  localparam cfg_index_t REG_SYNC   = 8'd1;
  localparam cfg_index_t REG_EXCODE = 8'd2;
  localparam cfg_index_t REG_MAXLEN = 8'd3;

  localparam byte_t SYNC_RESET     = 8'd170;
  localparam byte_t EXCODE_RESET   = 8'd85;
  localparam byte_t MAXLEN_RESET   = 8'd169;
  localparam byte_t RESERVED_LEN   = 8'd170;
  localparam byte_t LONG_CODE_MIN  = 8'h80;
  localparam byte_t RAW_TAG_MASK   = 8'hC0;
  localparam byte_t RAW_HIGH_TAG   = 8'h80;
  localparam byte_t RAW_LOW_TAG    = 8'h40;

  localparam logic [2:0] LEVEL_MAX = 3'd7;

endpackage

// ----- hw/rtl/sync_packet_row_deframer_unit.sv -----
// ---------------------------------------------------------------------------
// sync_packet_row_deframer_unit
// byte-serial sync/length/payload/checksum deframer with row decode and
// a two-byte raw sample mode
// ---------------------------------------------------------------------------
// Takes one byte per request and gives exactly one result request per byte.
// The byte is decoded in the cycle it is accepted and its result appears in
// the output register on the next cycle, so the unit sustains one byte per
// clock unless stalled; the single output register is the only buffer, and a
// new byte is taken when that register is empty or being emptied in the same
// cycle. Config writes are always ready; a mode write restarts the parser.
module sync_packet_row_deframer_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sprd_pkg::byte_t       in_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sprd_pkg::kind_t       out_kind,
  output logic [2:0]            out_ext_level,
  output sprd_pkg::byte_t       out_row_code,
  output sprd_pkg::byte_t       out_row_length,
  output sprd_pkg::byte_t       out_value_byte,
  output sprd_pkg::byte_t       out_value_index,
  output logic                  out_row_last,
  output sprd_pkg::status_t     out_status,
  output logic [15:0]           out_raw_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sprd_pkg::cfg_index_t  cfg_index,
  input  sprd_pkg::byte_t       cfg_data
);

  import sprd_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_SYNC1, PH_SYNC2, PH_LENGTH, PH_PAYLOAD, PH_CHKSUM, PH_HIGH, PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    RP_CODE, RP_LEN, RP_VALUE
  } row_phase_t;

  logic       mode_r,   mode_nxt;
  byte_t      sync_r,   sync_nxt;
  byte_t      excode_r, excode_nxt;
  byte_t      maxlen_r, maxlen_nxt;

  phase_t     phase_r,  phase_nxt;
  row_phase_t rphase_r, rphase_nxt;
  byte_t      len_r,    len_nxt;
  byte_t      rcv_r,    rcv_nxt;
  byte_t      sum_r,    sum_nxt;
  logic [2:0] lvl_r,    lvl_nxt;
  byte_t      code_r,   code_nxt;
  byte_t      rem_r,    rem_nxt;
  byte_t      pos_r,    pos_nxt;
  byte_t      prev_r,   prev_nxt;

  logic       out_valid_r, out_valid_nxt;
  kind_t      kind_r,   kind_nxt;
  logic [2:0] ext_r,    ext_nxt;
  byte_t      rcode_r,  rcode_nxt;
  byte_t      rlen_r,   rlen_nxt;
  byte_t      val_r,    val_nxt;
  byte_t      vidx_r,   vidx_nxt;
  logic       last_r,   last_nxt;
  status_t    status_r, status_nxt;
  logic [15:0] raw_r,   raw_nxt;

  logic       in_take;
  logic       cfg_take;

  assign in_stall  = out_valid_r && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_comb begin
    mode_nxt   = mode_r;
    sync_nxt   = sync_r;
    excode_nxt = excode_r;
    maxlen_nxt = maxlen_r;
    phase_nxt  = phase_r;
    rphase_nxt = rphase_r;
    len_nxt    = len_r;
    rcv_nxt    = rcv_r;
    sum_nxt    = sum_r;
    lvl_nxt    = lvl_r;
    code_nxt   = code_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;

    kind_nxt   = KIND_SYNC;
    ext_nxt    = 3'd0;
    rcode_nxt  = 8'd0;
    rlen_nxt   = 8'd0;
    val_nxt    = 8'd0;
    vidx_nxt   = 8'd0;
    last_nxt   = 1'b0;
    status_nxt = STATUS_NONE;
    raw_nxt    = 16'd0;

    if (cfg_take) begin
      unique case (cfg_index)
        REG_MODE: begin
          mode_nxt   = cfg_data[0];
          phase_nxt  = cfg_data[0] ? PH_HIGH : PH_SYNC1;
          len_nxt    = 8'd0;
          rcv_nxt    = 8'd0;
          sum_nxt    = 8'd0;
          rphase_nxt = RP_CODE;
          lvl_nxt    = 3'd0;
          code_nxt   = 8'd0;
          rem_nxt    = 8'd0;
          pos_nxt    = 8'd0;
        end
        REG_SYNC:   sync_nxt   = cfg_data;
        REG_EXCODE: excode_nxt = cfg_data;
        REG_MAXLEN: maxlen_nxt = cfg_data;
        default: ;
      endcase
    end else if (in_take) begin
      prev_nxt = in_byte;
      unique case (phase_r)
        PH_SYNC1: begin
          if (in_byte == sync_r) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_nxt = (in_byte == sync_r) ? PH_LENGTH : PH_SYNC1;
        end
        PH_LENGTH: begin
          kind_nxt = KIND_LENGTH;
          if (in_byte == RESERVED_LEN) begin
            status_nxt = STATUS_RESERVED;
          end else if (in_byte == 8'd0) begin
            status_nxt = STATUS_ZERO_LEN;
            phase_nxt  = PH_SYNC1;
          end else if (in_byte > maxlen_r) begin
            status_nxt = STATUS_TOO_LONG;
            phase_nxt  = PH_SYNC1;
          end else begin
            len_nxt    = in_byte;
            rcv_nxt    = 8'd0;
            sum_nxt    = 8'd0;
            rphase_nxt = RP_CODE;
            lvl_nxt    = 3'd0;
            code_nxt   = 8'd0;
            rem_nxt    = 8'd0;
            pos_nxt    = 8'd0;
            phase_nxt  = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt = sum_r + in_byte;
          rcv_nxt = rcv_r + 8'd1;
          unique case (rphase_r)
            RP_CODE: begin
              if (in_byte == excode_r) begin
                if (lvl_r != LEVEL_MAX) begin
                  lvl_nxt = lvl_r + 3'd1;
                end
                kind_nxt = KIND_EXCODE;
                ext_nxt  = (lvl_r != LEVEL_MAX) ? lvl_r + 3'd1 : lvl_r;
              end else begin
                code_nxt  = in_byte;
                kind_nxt  = KIND_CODE;
                ext_nxt   = lvl_r;
                rcode_nxt = in_byte;
                pos_nxt   = 8'd0;
                if (in_byte >= LONG_CODE_MIN) begin
                  rphase_nxt = RP_LEN;
                end else begin
                  rem_nxt    = 8'd1;
                  rlen_nxt   = 8'd1;
                  rphase_nxt = RP_VALUE;
                end
              end
            end
            RP_LEN: begin
              kind_nxt  = KIND_VLEN;
              ext_nxt   = lvl_r;
              rcode_nxt = code_r;
              rlen_nxt  = in_byte;
              pos_nxt   = 8'd0;
              if (in_byte == 8'd0) begin
                rphase_nxt = RP_CODE;
                lvl_nxt    = 3'd0;
                code_nxt   = 8'd0;
                rem_nxt    = 8'd0;
              end else begin
                rem_nxt    = in_byte;
                rphase_nxt = RP_VALUE;
              end
            end
            default: begin
              kind_nxt  = KIND_VALUE;
              ext_nxt   = lvl_r;
              rcode_nxt = code_r;
              rlen_nxt  = pos_r + rem_r;
              val_nxt   = in_byte;
              vidx_nxt  = pos_r;
              last_nxt  = (rem_r <= 8'd1);
              pos_nxt   = pos_r + 8'd1;
              rem_nxt   = (rem_r != 8'd0) ? rem_r - 8'd1 : rem_r;
              if (rem_r <= 8'd1) begin
                rphase_nxt = RP_CODE;
                lvl_nxt    = 3'd0;
                code_nxt   = 8'd0;
                rem_nxt    = 8'd0;
                pos_nxt    = 8'd0;
              end
            end
          endcase
          if (rcv_r + 8'd1 >= len_r) begin
            phase_nxt = PH_CHKSUM;
          end
        end
        PH_CHKSUM: begin
          kind_nxt = KIND_CHKSUM;
          if (in_byte != ~sum_r) begin
            status_nxt = STATUS_BAD_SUM;
          end else if (rphase_r != RP_CODE || lvl_r != 3'd0) begin
            status_nxt = STATUS_OVERRUN;
          end else begin
            status_nxt = STATUS_OK;
          end
          rphase_nxt = RP_CODE;
          lvl_nxt    = 3'd0;
          code_nxt   = 8'd0;
          rem_nxt    = 8'd0;
          pos_nxt    = 8'd0;
          phase_nxt  = PH_SYNC1;
        end
        PH_HIGH: begin
          if ((in_byte & RAW_TAG_MASK) == RAW_HIGH_TAG) begin
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if ((in_byte & RAW_TAG_MASK) == RAW_LOW_TAG) begin
            kind_nxt = KIND_RAW;
            raw_nxt  = {prev_r, in_byte};
          end
          phase_nxt = PH_HIGH;
        end
        default: begin
          phase_nxt  = mode_r ? PH_HIGH : PH_SYNC1;
          len_nxt    = 8'd0;
          rcv_nxt    = 8'd0;
          sum_nxt    = 8'd0;
          rphase_nxt = RP_CODE;
          lvl_nxt    = 3'd0;
          code_nxt   = 8'd0;
          rem_nxt    = 8'd0;
          pos_nxt    = 8'd0;
        end
      endcase
    end

    if (in_take) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      sync_r      <= SYNC_RESET;
      excode_r    <= EXCODE_RESET;
      maxlen_r    <= MAXLEN_RESET;
      phase_r     <= PH_SYNC1;
      rphase_r    <= RP_CODE;
      len_r       <= 8'd0;
      rcv_r       <= 8'd0;
      sum_r       <= 8'd0;
      lvl_r       <= 3'd0;
      code_r      <= 8'd0;
      rem_r       <= 8'd0;
      pos_r       <= 8'd0;
      prev_r      <= 8'd0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_SYNC;
      ext_r       <= 3'd0;
      rcode_r     <= 8'd0;
      rlen_r      <= 8'd0;
      val_r       <= 8'd0;
      vidx_r      <= 8'd0;
      last_r      <= 1'b0;
      status_r    <= STATUS_NONE;
      raw_r       <= 16'd0;
    end else begin
      mode_r      <= mode_nxt;
      sync_r      <= sync_nxt;
      excode_r    <= excode_nxt;
      maxlen_r    <= maxlen_nxt;
      phase_r     <= phase_nxt;
      rphase_r    <= rphase_nxt;
      len_r       <= len_nxt;
      rcv_r       <= rcv_nxt;
      sum_r       <= sum_nxt;
      lvl_r       <= lvl_nxt;
      code_r      <= code_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      // result payload, loaded only with a new request
      if (in_take) begin
        kind_r   <= kind_nxt;
        ext_r    <= ext_nxt;
        rcode_r  <= rcode_nxt;
        rlen_r   <= rlen_nxt;
        val_r    <= val_nxt;
        vidx_r   <= vidx_nxt;
        last_r   <= last_nxt;
        status_r <= status_nxt;
        raw_r    <= raw_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_ext_level   = ext_r;
  assign out_row_code    = rcode_r;
  assign out_row_length  = rlen_r;
  assign out_value_byte  = val_r;
  assign out_value_index = vidx_r;
  assign out_row_last    = last_r;
  assign out_status      = status_r;
  assign out_raw_sample  = raw_r;

  `ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, in_stall, out_valid_r)
  `ASSERT_IMPLY(a_raw_phase_mode, clk, rst_n,
                phase_r == PH_HIGH || phase_r == PH_LOW, mode_r)
  `ASSERT_IMPLY(a_value_pending, clk, rst_n, rphase_r == RP_VALUE, rem_r != 8'd0)
  `ASSERT_NEXT(a_frame_kinds_no_level, clk, rst_n,
               in_take && (kind_nxt == KIND_SYNC || kind_nxt == KIND_LENGTH ||
               kind_nxt == KIND_CHKSUM || kind_nxt == KIND_RAW),
               out_ext_level == 3'd0 && out_row_code == 8'd0)

endmodule
